FILE: rtl/gzr_pkg.sv
// Shared types and constants for the gyro zero-rate autocalibration block.
`timescale 1ns / 1ps

package gzr_pkg;

  localparam int COUNT_W = 17;
  localparam int STILL_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 23;
  localparam int LIMIT_W = 23;
  localparam int TARGET_W = 16;
  localparam int ALPHA_W = 9;
  localparam int ALPHA_SHIFT = 8;
  localparam int KIND_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [STILL_W-1:0] STILL_MAX = '1;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_TARGET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOTION_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_Q8 = 3'd4;

  // register reset values
  localparam logic [TARGET_W-1:0] TARGET_RST = 16'd6000;
  localparam logic [LIMIT_W-1:0] MOTION_RST = 23'd3491;
  localparam logic [LIMIT_W-1:0] NOISE_RST = 23'd300;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 9'd102;

  // offset kinds
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TEMP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PERM = 2'd2;

  typedef enum logic [1:0] {
    MUL_AX,  // alpha * sample
    MUL_BS,  // (1 - alpha) * smoothed rate
    MUL_SC,  // smoothed rate * count
    MUL_NC   // noise limit * count
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SM_AX,
    ST_SM_BS,
    ST_SM_UPD,
    ST_MOT,
    ST_DIF,
    ST_CHK,
    ST_ADD,
    ST_PASS_DEC,
    ST_FAIL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_CLEAR,
    ST_OUT
  } state_t;

endpackage

FILE: rtl/gzr_sample_if.sv
// Input channel: one three-axis gyro sample per word.
`timescale 1ns / 1ps

interface gzr_sample_if #(
  parameter int SAMPLE_BITS = 24
);
  logic valid;
  logic ready;
  logic signed [SAMPLE_BITS-1:0] gyro_x;
  logic signed [SAMPLE_BITS-1:0] gyro_y;
  logic signed [SAMPLE_BITS-1:0] gyro_z;

  modport source(output valid, output gyro_x, output gyro_y, output gyro_z, input ready);
  modport sink(input valid, input gyro_x, input gyro_y, input gyro_z, output ready);
endinterface

FILE: rtl/gzr_result_if.sv
// Output channel: offset report per sample.
`timescale 1ns / 1ps

interface gzr_result_if #(
  parameter int SAMPLE_BITS = 24
);
  logic valid;
  logic ready;
  logic [1:0] offset_kind;
  logic signed [SAMPLE_BITS-1:0] offset_x;
  logic signed [SAMPLE_BITS-1:0] offset_y;
  logic signed [SAMPLE_BITS-1:0] offset_z;
  logic calibrated;
  logic [31:0] still_count;

  modport source(output valid, output offset_kind, output offset_x, output offset_y,
                 output offset_z, output calibrated, output still_count, input ready);
  modport sink(input valid, input offset_kind, input offset_x, input offset_y,
               input offset_z, input calibrated, input still_count, output ready);
endinterface

FILE: rtl/gzr_mul.sv
// Shared registered multiplier with operand select for smoothing and mean tests.
`timescale 1ns / 1ps

module gzr_mul #(
  parameter int SAMPLE_BITS = 24,
  parameter int SMOOTH_FRAC_BITS = 8
) (
  input  logic clk,
  input  gzr_pkg::mul_sel_t sel,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [SAMPLE_BITS+SMOOTH_FRAC_BITS-1:0] smooth,
  input  logic [gzr_pkg::ALPHA_W-1:0] alpha,
  input  logic [gzr_pkg::LIMIT_W-1:0] noise,
  input  logic [gzr_pkg::COUNT_W-1:0] count,
  output logic signed [((SAMPLE_BITS+SMOOTH_FRAC_BITS > 24) ?
                        SAMPLE_BITS+SMOOTH_FRAC_BITS : 24)+17:0] prod
);

  localparam int SW = SAMPLE_BITS + SMOOTH_FRAC_BITS;
  localparam int MA = (SW > 24) ? SW : 24;
  localparam int MB = 18;

  logic signed [MA-1:0] op_a;
  logic signed [MB-1:0] op_b;
  logic [gzr_pkg::ALPHA_W-1:0] alpha_inv;

  assign alpha_inv = gzr_pkg::ALPHA_ONE - alpha;

  always_comb begin
    case (sel)
      gzr_pkg::MUL_AX: begin
        op_a = {{(MA-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
        op_b = {{(MB-gzr_pkg::ALPHA_W){1'b0}}, alpha};
      end
      gzr_pkg::MUL_BS: begin
        op_a = {{(MA-SW){smooth[SW-1]}}, smooth};
        op_b = {{(MB-gzr_pkg::ALPHA_W){1'b0}}, alpha_inv};
      end
      gzr_pkg::MUL_SC: begin
        op_a = {{(MA-SW){smooth[SW-1]}}, smooth};
        op_b = {{(MB-gzr_pkg::COUNT_W){1'b0}}, count};
      end
      default: begin
        op_a = {{(MA-gzr_pkg::LIMIT_W){1'b0}}, noise};
        op_b = {{(MB-gzr_pkg::COUNT_W){1'b0}}, count};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

FILE: rtl/gzr_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating.
`timescale 1ns / 1ps

module gzr_div #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [SAMPLE_BITS+gzr_pkg::COUNT_W-1:0] dividend,
  input  logic [gzr_pkg::COUNT_W-1:0] divisor,
  output logic done,
  output logic signed [SAMPLE_BITS-1:0] quotient
);

  localparam int NW = SAMPLE_BITS + gzr_pkg::COUNT_W;
  localparam int CW = gzr_pkg::COUNT_W;
  localparam int IW = $clog2(NW + 1);

  logic [NW-1:0] q;
  logic [CW-1:0] rem;
  logic [CW-1:0] dvs;
  logic neg;
  logic busy;
  logic [IW-1:0] iter;
  logic [CW:0] rem_sh;
  logic [CW:0] rem_diff;
  logic [NW-1:0] q_signed;

  assign rem_sh = {rem, q[NW-1]};
  assign rem_diff = rem_sh - {1'b0, dvs};
  assign q_signed = neg ? -q : q;
  assign quotient = q_signed[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && iter == IW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend[NW-1] ? -dividend : dividend;
      neg <= dividend[NW-1];
      rem <= '0;
      dvs <= divisor;
      iter <= IW'(NW);
    end else if (busy) begin
      // restoring step
      if (!rem_diff[CW]) begin
        rem <= rem_diff[CW-1:0];
        q <= {q[NW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[CW-1:0];
        q <= {q[NW-2:0], 1'b0};
      end
      iter <= iter - IW'(1);
    end
  end

endmodule

FILE: rtl/gyro_zero_rate_autocalibrate.sv
// Gyro zero-rate bias estimator. Each sample word is taken only while the block is idle.
// The first sample after a clear is summed without any test. Any other sample runs through
// a sequencer around one shared registered multiplier: per tested axis, smoothing,
// motion test and mean test, then summing once all three axes pass; a failing test
// skips the remaining axes. When an offset is emitted, one shared divider
// forms the three means at one quotient bit per cycle, and the sums are then cleared.
// A finished result waits in an output register, so the next sample is taken while it
// is still pending; a later result stalls in the sequencer until that register is free.
`timescale 1ns / 1ps

module gyro_zero_rate_autocalibrate #(
  parameter int SAMPLE_BITS = 24,
  parameter int SMOOTH_FRAC_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  gzr_sample_if.sink sample,
  gzr_result_if.source result,
  input  logic cfg_we,
  input  logic [gzr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gzr_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int F = SMOOTH_FRAC_BITS;
  localparam int SW = SAMPLE_BITS + F;
  localparam int SUMW = SAMPLE_BITS + gzr_pkg::COUNT_W;
  localparam int DW = SW + 18;
  localparam int SMW = SW + 10;
  localparam int MA = (SW > 24) ? SW : 24;
  localparam int PW = MA + 18;
  localparam int LW = gzr_pkg::LIMIT_W;
  localparam int CW = gzr_pkg::COUNT_W;

  // configuration
  logic auto_enable;
  logic [gzr_pkg::TARGET_W-1:0] sample_target;
  logic [LW-1:0] motion_limit;
  logic [LW-1:0] noise_limit;
  logic [gzr_pkg::ALPHA_W-1:0] alpha_q8;

  // estimator state
  logic signed [SW-1:0] smoothed_rate [3];
  logic signed [SUMW-1:0] rate_sum [3];
  logic [CW-1:0] sum_count;
  logic [gzr_pkg::STILL_W-1:0] still_run;

  // per-sample working registers
  gzr_pkg::state_t state, state_next;
  logic signed [SAMPLE_BITS-1:0] gx [3];
  logic [1:0] axis;
  logic signed [DW-1:0] acc;
  logic tested;
  logic fail_flag;
  logic [gzr_pkg::KIND_W-1:0] kind;
  logic signed [SAMPLE_BITS-1:0] off [3];
  logic cal;

  // result register
  logic res_valid;
  logic [gzr_pkg::KIND_W-1:0] res_kind;
  logic signed [SAMPLE_BITS-1:0] res_x;
  logic signed [SAMPLE_BITS-1:0] res_y;
  logic signed [SAMPLE_BITS-1:0] res_z;
  logic res_cal;
  logic [gzr_pkg::STILL_W-1:0] res_still;

  // control
  gzr_pkg::mul_sel_t mul_sel;
  logic div_start;
  logic in_ready;
  logic accept;
  logic out_free;

  // datapath
  logic [gzr_pkg::ALPHA_W-1:0] alpha_eff;
  logic signed [PW-1:0] prod;
  logic signed [SW-1:0] s_cur;
  logic signed [SUMW-1:0] sum_cur;
  logic signed [SMW-1:0] sm_acc;
  logic signed [SMW-1:0] sm_prod;
  logic signed [SMW-1:0] sm_sum;
  logic signed [SMW-1:0] sm_shift;
  logic signed [SW-1:0] s_new;
  logic [SW-1:0] s_mag;
  logic [SW+LW-1:0] s_mag_x;
  logic [SW+LW-1:0] mot_lim_x;
  logic motion_fail;
  logic signed [DW-F-1:0] sum_sx;
  logic signed [DW-1:0] diff;
  logic [DW-1:0] acc_mag;
  logic [PW+F-1:0] acc_mag_x;
  logic [PW+F-1:0] noise_lim;
  logic noise_fail;
  logic emit_temp;
  logic emit_perm;
  logic div_done;
  logic signed [SAMPLE_BITS-1:0] div_quot;

  assign alpha_eff = (alpha_q8[gzr_pkg::ALPHA_W-1] && (|alpha_q8[gzr_pkg::ALPHA_W-2:0])) ?
                     gzr_pkg::ALPHA_ONE : alpha_q8;

  assign s_cur = smoothed_rate[axis];
  assign sum_cur = rate_sum[axis];

  // new smoothed rate: floor((a*x<<F + (256-a)*s) / 256)
  assign sm_acc = acc[SMW-1:0];
  assign sm_prod = prod[SMW-1:0];
  assign sm_sum = sm_acc + sm_prod;
  assign sm_shift = sm_sum >>> gzr_pkg::ALPHA_SHIFT;
  assign s_new = sm_shift[SW-1:0];

  assign s_mag = s_cur[SW-1] ? -s_cur : s_cur;
  assign s_mag_x = {{LW{1'b0}}, s_mag};
  assign mot_lim_x = {{SAMPLE_BITS{1'b0}}, motion_limit, {F{1'b0}}};
  assign motion_fail = s_mag_x >= mot_lim_x;

  // distance of s*count from sum<<F
  assign sum_sx = {{(DW-F-SUMW){sum_cur[SUMW-1]}}, sum_cur};
  assign diff = prod[DW-1:0] - {sum_sx, {F{1'b0}}};

  assign acc_mag = acc[DW-1] ? -acc : acc;
  assign acc_mag_x = {{(PW+F-DW){1'b0}}, acc_mag};
  assign noise_lim = {prod, {F{1'b0}}};
  assign noise_fail = acc_mag_x >= noise_lim;

  assign emit_temp = auto_enable &&
                     (sum_count > {{(CW-gzr_pkg::TARGET_W+1){1'b0}},
                                   sample_target[gzr_pkg::TARGET_W-1:1]});
  assign emit_perm = auto_enable &&
                     (sum_count > {{(CW-gzr_pkg::TARGET_W){1'b0}}, sample_target});

  assign accept = sample.valid && in_ready;
  assign out_free = !res_valid || result.ready;

  gzr_mul #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .SMOOTH_FRAC_BITS(SMOOTH_FRAC_BITS)
  ) u_mul (
    .clk(clk),
    .sel(mul_sel),
    .sample(gx[axis]),
    .smooth(s_cur),
    .alpha(alpha_eff),
    .noise(noise_limit),
    .count(sum_count),
    .prod(prod)
  );

  gzr_div #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(sum_cur),
    .divisor(sum_count),
    .done(div_done),
    .quotient(div_quot)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      gzr_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (sum_count == '0) ? gzr_pkg::ST_ADD : gzr_pkg::ST_SM_AX;
        end
      end
      gzr_pkg::ST_SM_AX:  state_next = gzr_pkg::ST_SM_BS;
      gzr_pkg::ST_SM_BS:  state_next = gzr_pkg::ST_SM_UPD;
      gzr_pkg::ST_SM_UPD: state_next = gzr_pkg::ST_MOT;
      gzr_pkg::ST_MOT: begin
        state_next = motion_fail ? gzr_pkg::ST_FAIL : gzr_pkg::ST_DIF;
      end
      gzr_pkg::ST_DIF: state_next = gzr_pkg::ST_CHK;
      gzr_pkg::ST_CHK: begin
        if (noise_fail) begin
          state_next = gzr_pkg::ST_FAIL;
        end else if (axis == 2'd2) begin
          state_next = gzr_pkg::ST_ADD;
        end else begin
          state_next = gzr_pkg::ST_SM_AX;
        end
      end
      gzr_pkg::ST_ADD: begin
        state_next = tested ? gzr_pkg::ST_PASS_DEC : gzr_pkg::ST_OUT;
      end
      gzr_pkg::ST_PASS_DEC: begin
        state_next = emit_perm ? gzr_pkg::ST_DIV_START : gzr_pkg::ST_OUT;
      end
      gzr_pkg::ST_FAIL: begin
        state_next = emit_temp ? gzr_pkg::ST_DIV_START : gzr_pkg::ST_CLEAR;
      end
      gzr_pkg::ST_DIV_START: state_next = gzr_pkg::ST_DIV_WAIT;
      gzr_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = (axis == 2'd2) ? gzr_pkg::ST_CLEAR : gzr_pkg::ST_DIV_START;
        end
      end
      gzr_pkg::ST_CLEAR: state_next = gzr_pkg::ST_OUT;
      gzr_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = gzr_pkg::ST_IDLE;
        end
      end
      default: state_next = gzr_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    div_start = 1'b0;
    mul_sel = gzr_pkg::MUL_AX;
    unique case (state)
      gzr_pkg::ST_IDLE:      in_ready = 1'b1;
      gzr_pkg::ST_SM_AX:     mul_sel = gzr_pkg::MUL_AX;
      gzr_pkg::ST_SM_BS:     mul_sel = gzr_pkg::MUL_BS;
      gzr_pkg::ST_MOT:       mul_sel = gzr_pkg::MUL_SC;
      gzr_pkg::ST_DIF:       mul_sel = gzr_pkg::MUL_NC;
      gzr_pkg::ST_DIV_START: div_start = 1'b1;
      default: begin
      end
    endcase
  end

  assign sample.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gzr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      auto_enable <= 1'b0;
      sample_target <= gzr_pkg::TARGET_RST;
      motion_limit <= gzr_pkg::MOTION_RST;
      noise_limit <= gzr_pkg::NOISE_RST;
      alpha_q8 <= gzr_pkg::ALPHA_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gzr_pkg::REG_AUTO_ENABLE:   auto_enable <= cfg_data[0];
        gzr_pkg::REG_SAMPLE_TARGET: sample_target <= cfg_data[gzr_pkg::TARGET_W-1:0];
        gzr_pkg::REG_MOTION_LIMIT:  motion_limit <= cfg_data[LW-1:0];
        gzr_pkg::REG_NOISE_LIMIT:   noise_limit <= cfg_data[LW-1:0];
        gzr_pkg::REG_ALPHA_Q8:      alpha_q8 <= cfg_data[gzr_pkg::ALPHA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // estimator state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        smoothed_rate[i] <= '0;
        rate_sum[i] <= '0;
      end
      sum_count <= '0;
      still_run <= '0;
    end else begin
      if (state == gzr_pkg::ST_SM_UPD) begin
        smoothed_rate[axis] <= s_new;
      end
      if (state == gzr_pkg::ST_ADD) begin
        // a full count stops summing; the tests still run
        if (sum_count != gzr_pkg::COUNT_MAX) begin
          for (int i = 0; i < 3; i++) begin
            rate_sum[i] <= rate_sum[i] +
                           {{(SUMW-SAMPLE_BITS){gx[i][SAMPLE_BITS-1]}}, gx[i]};
          end
          sum_count <= sum_count + CW'(1);
        end
        if (tested && still_run != gzr_pkg::STILL_MAX) begin
          still_run <= still_run + gzr_pkg::STILL_W'(1);
        end
      end
      if (state == gzr_pkg::ST_CLEAR) begin
        for (int i = 0; i < 3; i++) begin
          rate_sum[i] <= '0;
        end
        sum_count <= '0;
        if (fail_flag) begin
          still_run <= '0;
        end
      end
    end
  end

  // per-sample working registers
  always_ff @(posedge clk) begin
    unique case (state)
      gzr_pkg::ST_IDLE: begin
        if (accept) begin
          gx[0] <= sample.gyro_x;
          gx[1] <= sample.gyro_y;
          gx[2] <= sample.gyro_z;
          axis <= 2'd0;
          tested <= (sum_count != '0);
          fail_flag <= 1'b0;
          kind <= gzr_pkg::KIND_NONE;
          cal <= 1'b0;
          for (int i = 0; i < 3; i++) begin
            off[i] <= '0;
          end
        end
      end
      gzr_pkg::ST_SM_BS: acc <= {prod[DW-F-1:0], {F{1'b0}}};
      gzr_pkg::ST_DIF:   acc <= diff;
      gzr_pkg::ST_CHK: begin
        if (!noise_fail && axis != 2'd2) begin
          axis <= axis + 2'd1;
        end
      end
      gzr_pkg::ST_PASS_DEC: begin
        if (emit_perm) begin
          kind <= gzr_pkg::KIND_PERM;
          cal <= 1'b1;
          axis <= 2'd0;
        end
      end
      gzr_pkg::ST_FAIL: begin
        fail_flag <= 1'b1;
        axis <= 2'd0;
        if (emit_temp) begin
          kind <= gzr_pkg::KIND_TEMP;
        end
      end
      gzr_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          off[axis] <= div_quot;
          if (axis != 2'd2) begin
            axis <= axis + 2'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == gzr_pkg::ST_OUT && out_free) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == gzr_pkg::ST_OUT && out_free) begin
      res_kind <= kind;
      res_x <= off[0];
      res_y <= off[1];
      res_z <= off[2];
      res_cal <= cal;
      res_still <= still_run;
    end
  end

  assign result.valid = res_valid;
  assign result.offset_kind = res_kind;
  assign result.offset_x = res_x;
  assign result.offset_y = res_y;
  assign result.offset_z = res_z;
  assign result.calibrated = res_cal;
  assign result.still_count = res_still;

endmodule

FILE: bench/gzr_offset_checker.sv
// Offset report checker: predicts each report from the accepted sample words and compares.
`timescale 1ns / 1ps

module gzr_offset_checker
  import gzr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  gzr_sample_if sample,
  gzr_result_if result,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int errors,
  output int pending,
  output int temp_seen,
  output int perm_seen
);

  localparam int GYRO_W = 24;
  localparam longint Q8_ONE = 256;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [GYRO_W-1:0] ox;
    logic [GYRO_W-1:0] oy;
    logic [GYRO_W-1:0] oz;
    logic cal;
    logic [STILL_W-1:0] still;
  } offset_report_t;

  // register copies
  logic auto_en;
  logic [TARGET_W-1:0] target;
  logic [LIMIT_W-1:0] motion_lim;
  logic [LIMIT_W-1:0] noise_lim;
  logic [ALPHA_W-1:0] alpha;

  // estimator state
  longint smooth_q8[3];
  longint rate_acc[3];
  int unsigned acc_count;
  logic [STILL_W-1:0] still_len;

  offset_report_t report_q[$];
  int reports_seen;

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void sum_sample(input longint gx, input longint gy, input longint gz);
    if (acc_count < COUNT_MAX) begin
      rate_acc[0] += gx;
      rate_acc[1] += gy;
      rate_acc[2] += gz;
      acc_count++;
    end
  endfunction

  function automatic void clear_sums();
    for (int i = 0; i < 3; i++) rate_acc[i] = 0;
    acc_count = 0;
  endfunction

  // means truncate toward zero, as signed division does
  function automatic offset_report_t with_means(input offset_report_t r);
    longint cnt;
    cnt = longint'(acc_count);
    r.ox = GYRO_W'(rate_acc[0] / cnt);
    r.oy = GYRO_W'(rate_acc[1] / cnt);
    r.oz = GYRO_W'(rate_acc[2] / cnt);
    return r;
  endfunction

  function automatic offset_report_t estimate_offset(input longint gx, input longint gy,
                                                     input longint gz);
    longint smp[3];
    longint a;
    longint cnt;
    longint s;
    longint d;
    logic fail;
    offset_report_t r;
    r = '0;
    smp[0] = gx;
    smp[1] = gy;
    smp[2] = gz;
    fail = 1'b0;
    if (acc_count == 0) begin
      sum_sample(gx, gy, gz);
    end else begin
      if (alpha > ALPHA_ONE) a = longint'(ALPHA_ONE);
      else a = longint'(alpha);
      cnt = longint'(acc_count);
      // axes after the first failing one keep their smoothed rate
      for (int i = 0; i < 3 && !fail; i++) begin
        s = (a * smp[i] * Q8_ONE + (longint'(ALPHA_ONE) - a) * smooth_q8[i]) >>> ALPHA_SHIFT;
        smooth_q8[i] = s;
        if (magnitude(s) >= longint'(motion_lim) * Q8_ONE) begin
          fail = 1'b1;
        end else begin
          d = s * cnt - rate_acc[i] * Q8_ONE;
          if (magnitude(d) >= longint'(noise_lim) * Q8_ONE * cnt) fail = 1'b1;
        end
      end
      if (fail) begin
        if (auto_en && acc_count > target / 2) begin
          r.kind = KIND_TEMP;
          r = with_means(r);
        end
        clear_sums();
        still_len = '0;
      end else begin
        sum_sample(gx, gy, gz);
        if (still_len != STILL_MAX) still_len++;
        if (auto_en && acc_count > target) begin
          r.kind = KIND_PERM;
          r.cal = 1'b1;
          r = with_means(r);
          clear_sums();
        end
      end
    end
    r.still = still_len;
    return r;
  endfunction

  always @(posedge clk) begin
    offset_report_t want;
    offset_report_t got;
    if (rst) begin
      auto_en = 1'b0;
      target = TARGET_RST;
      motion_lim = MOTION_RST;
      noise_lim = NOISE_RST;
      alpha = ALPHA_RST;
      for (int i = 0; i < 3; i++) smooth_q8[i] = 0;
      clear_sums();
      still_len = '0;
      report_q.delete();
      errors = 0;
      pending = 0;
      temp_seen = 0;
      perm_seen = 0;
      reports_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_AUTO_ENABLE: auto_en = cfg_data[0];
          REG_SAMPLE_TARGET: target = cfg_data[TARGET_W-1:0];
          REG_MOTION_LIMIT: motion_lim = cfg_data[LIMIT_W-1:0];
          REG_NOISE_LIMIT: noise_lim = cfg_data[LIMIT_W-1:0];
          REG_ALPHA_Q8: alpha = cfg_data[ALPHA_W-1:0];
          default: ;
        endcase
      end
      // result first: a sample word taken at this edge cannot report at the same edge
      if (result.valid && result.ready) begin
        reports_seen++;
        got.kind = result.offset_kind;
        got.ox = result.offset_x;
        got.oy = result.offset_y;
        got.oz = result.offset_z;
        got.cal = result.calibrated;
        got.still = result.still_count;
        if (report_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("report %0d arrived with no sample outstanding", reports_seen);
        end else begin
          want = report_q.pop_front();
          if (got.kind == KIND_TEMP) temp_seen++;
          if (got.kind == KIND_PERM) perm_seen++;
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"report %0d mismatch: expected kind %0d off %0d %0d %0d cal %0b ",
                        "still %0d, got kind %0d off %0d %0d %0d cal %0b still %0d"},
                       reports_seen, want.kind, $signed(want.ox), $signed(want.oy),
                       $signed(want.oz), want.cal, want.still, got.kind, $signed(got.ox),
                       $signed(got.oy), $signed(got.oz), got.cal, got.still);
          end
        end
      end
      if (sample.valid && sample.ready)
        report_q.push_back(estimate_offset(longint'(sample.gyro_x), longint'(sample.gyro_y),
                                           longint'(sample.gyro_z)));
      pending = report_q.size();
    end
  end

endmodule

FILE: bench/gyro_zero_rate_autocalibrate_test.sv
// Top of the gyro zero-rate autocalibration bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module gyro_zero_rate_autocalibrate_test;
  import gzr_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam longint CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_PHASES = 19;
  localparam int PHASE_ITEMS = 100;
  localparam int GYRO_MAX = 8388607;
  localparam int GYRO_MIN = -8388608;
  localparam int LIMIT_MAX = 8388607;
  localparam int TARGET_MAX = 65535;
  localparam int ALPHA_FIELD_MAX = 511;
  localparam int ALPHA_FULL = 256;
  localparam int DRAIN_CYCLES = 200;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int errors;
  int pending;
  int temp_seen;
  int perm_seen;

  int burst_left;
  int max_burst;
  int max_gap;
  int samples_sent = 0;
  int settings_run = 0;
  logic [15:0] stall_pat = '1;
  logic [3:0] stall_pos = '0;
  longint cycles = 0;

  gzr_sample_if sample();
  gzr_result_if result();

  gyro_zero_rate_autocalibrate dut (
    .clk(clk),
    .rst(rst),
    .sample(sample),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  gzr_offset_checker bias_check (
    .clk(clk),
    .rst(rst),
    .sample(sample),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .errors(errors),
    .pending(pending),
    .temp_seen(temp_seen),
    .perm_seen(perm_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("gyro_zero_rate_autocalibrate_test: errors");
      $finish;
    end
  end

  // receiver stalls follow a rotating 16-bit pattern
  always @(negedge clk) begin
    result.ready <= stall_pat[stall_pos];
    stall_pos <= stall_pos + 4'd1;
  end

  function automatic int jitter(input int half);
    return int'($urandom_range(0, 2 * half)) - half;
  endfunction

  function automatic int clamp_rate(input longint v);
    if (v > GYRO_MAX) return GYRO_MAX;
    if (v < GYRO_MIN) return GYRO_MIN;
    return int'(v);
  endfunction

  // call at a falling edge; returns at the falling edge after the word is taken
  task automatic push_sample(input int x, input int y, input int z);
    int gap;
    if (burst_left == 0) begin
      gap = (max_gap == 0) ? 0 : int'($urandom_range(0, max_gap));
      if (gap > 0) begin
        sample.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, max_burst);
    end
    sample.valid <= 1'b1;
    sample.gyro_x <= 24'(x);
    sample.gyro_y <= 24'(y);
    sample.gyro_z <= 24'(z);
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    samples_sent++;
  endtask

  task automatic settle();
    sample.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic program_regs(input logic en, input int tgt, input int mot, input int noi,
                              input int alp);
    logic [CFG_DATA_W-1:0] vals[5];
    vals[REG_AUTO_ENABLE] = CFG_DATA_W'(en);
    vals[REG_SAMPLE_TARGET] = CFG_DATA_W'(tgt);
    vals[REG_MOTION_LIMIT] = CFG_DATA_W'(mot);
    vals[REG_NOISE_LIMIT] = CFG_DATA_W'(noi);
    vals[REG_ALPHA_Q8] = CFG_DATA_W'(alp);
    for (int i = REG_AUTO_ENABLE; i <= REG_ALPHA_Q8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  initial begin : stimulus
    int bias[3];
    int amp;
    int nz;
    int mot;
    int noi;
    int tgt;
    int alp;
    logic en;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample.valid = 1'b0;
    sample.gyro_x = '0;
    sample.gyro_y = '0;
    sample.gyro_z = '0;
    max_burst = 4;
    max_gap = 3;
    burst_left = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: full-scale words, motion failure, first word after a clear
    push_sample(GYRO_MAX, GYRO_MAX, GYRO_MAX);
    push_sample(GYRO_MIN, GYRO_MIN, GYRO_MIN);
    push_sample(0, 0, 0);
    push_sample(10, -10, 5);
    settle();

    // alpha above full scale, permanent then temporary offset with truncated means
    program_regs(1'b1, 4, LIMIT_MAX, LIMIT_MAX, ALPHA_FIELD_MAX);
    repeat (5) push_sample(-5, 7, 3);
    push_sample(3, -2, 1);
    push_sample(4, -3, 2);
    push_sample(4, -3, 2);
    push_sample(GYRO_MIN, GYRO_MAX, 0);
    settle();

    // alpha zero holds the smoothed rate; zero noise limit fails every test; target of one
    program_regs(1'b1, 1, 1000, 0, 0);
    push_sample(-7, -7, -7);
    push_sample(100, 0, 0);
    push_sample(5, 5, 5);
    push_sample(6, 6, 6);
    settle();

    // target of zero: every tested still word completes a calibration
    program_regs(1'b1, 0, LIMIT_MAX, LIMIT_MAX, 1);
    push_sample(1, 1, 1);
    push_sample(-1, -1, -1);
    push_sample(2, 3, 4);
    push_sample(GYRO_MAX, GYRO_MIN, GYRO_MAX);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      amp = 1 << $urandom_range(0, 22);
      nz = $urandom_range(0, amp / 8 + 1);
      for (int a = 0; a < 3; a++) bias[a] = jitter(amp);
      en = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 7))
        0: tgt = $urandom_range(0, 1);
        1: tgt = TARGET_MAX;
        2: tgt = $urandom_range(2, TARGET_MAX);
        default: tgt = $urandom_range(2, 40);
      endcase
      case ($urandom_range(0, 7))
        0: mot = 0;
        1: mot = LIMIT_MAX;
        default: mot = clamp_rate(longint'(2 * amp) + $urandom_range(0, 2 * amp));
      endcase
      case ($urandom_range(0, 7))
        0: noi = 0;
        1: noi = LIMIT_MAX;
        2: noi = $urandom_range(0, LIMIT_MAX);
        default: noi = 2 * nz + 1 + int'($urandom_range(0, 2 * nz + 1));
      endcase
      case ($urandom_range(0, 9))
        0: alp = 0;
        1: alp = $urandom_range(ALPHA_FULL + 1, ALPHA_FIELD_MAX);
        2: alp = 1;
        3: alp = ALPHA_FULL;
        default: alp = $urandom_range(1, ALPHA_FULL);
      endcase
      program_regs(en, tgt, mot, noi, alp);
      if ($urandom_range(0, 3) == 0) begin
        max_gap = 0;
        stall_pat <= '1;
      end else begin
        max_gap = $urandom_range(1, 20);
        max_burst = $urandom_range(1, 16);
        stall_pat <= 16'($urandom) | 16'h1;
      end
      // mostly words around a steady bias; occasional full-range spikes break the run
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 15) == 0)
          push_sample(int'($urandom), int'($urandom), int'($urandom));
        else
          push_sample(clamp_rate(longint'(bias[0]) + jitter(nz)),
                      clamp_rate(longint'(bias[1]) + jitter(nz)),
                      clamp_rate(longint'(bias[2]) + jitter(nz)));
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d sample words over %0d register settings",
             samples_sent, settings_run);
    $display("offsets checked: %0d temporary, %0d permanent", temp_seen, perm_seen);
    if (errors == 0 && pending == 0)
      $display("gyro_zero_rate_autocalibrate_test: clean");
    else
      $display("gyro_zero_rate_autocalibrate_test: errors");
    $finish;
  end

endmodule

FILE: files.f
rtl/gzr_pkg.sv
rtl/gzr_sample_if.sv
rtl/gzr_result_if.sv
rtl/gzr_mul.sv
rtl/gzr_div.sv
rtl/gyro_zero_rate_autocalibrate.sv
bench/gzr_offset_checker.sv
bench/gyro_zero_rate_autocalibrate_test.sv
